[design/clns_pkg.sv]
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, command codes and helpers for the character-LCD nibble
// sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_CMD     = 2'd1,
    OP_CHAR    = 2'd2,
    OP_CHAR_AT = 2'd3
  } op_e;

  localparam logic [1:0] LINE_FIRST  = 2'd1;
  localparam logic [1:0] LINE_SECOND = 2'd2;

  localparam logic [1:0] REG_POWER_UP  = 2'd0;
  localparam logic [1:0] REG_STROBE    = 2'd1;
  localparam logic [1:0] REG_INIT_TAIL = 2'd2;

  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] ADDR_LINE1     = 8'h80;
  localparam logic [7:0] ADDR_LINE2     = 8'hC0;

  localparam logic [1:0] INIT_LAST_IDX = 2'd3;

  localparam logic [15:0] RST_POWER_UP  = 16'd20000;
  localparam logic [7:0]  RST_STROBE    = 8'd40;
  localparam logic [15:0] RST_INIT_TAIL = 16'd5000;

  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned CFG_DATA_W  = 16;

  // One byte to put on the bus, with its strobe attributes
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       pwr;
    logic       tail;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic [15:0] power_up;
    logic [7:0]  strobe;
    logic [15:0] init_tail;
  } cfg_t;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      2'd0:    cmd = CMD_FUNC_SET;
      2'd1:    cmd = CMD_DISP_ON;
      2'd2:    cmd = CMD_ENTRY_MODE;
      default: cmd = CMD_CLEAR;
    endcase
    return cmd;
  endfunction

endpackage

[design/clns_front.sv]
// ----------------------------------------------------------------------------
// clns_front
// Accepts requests, classifies them and pushes one byte entry per cycle while the queue has room.
// ----------------------------------------------------------------------------
module clns_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_op_i,
  input  logic [7:0]         in_value_i,
  input  logic [5:0]         in_column_i,
  input  logic [1:0]         in_line_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output clns_pkg::byte_t    push_data_o
);

  logic                busy_q, busy_d;
  clns_pkg::op_e       op_q;
  logic [7:0]          val_q;
  logic [7:0]          addr_q;
  logic                has_addr_q;
  logic [1:0]          idx_q, idx_d;
  logic                push;
  logic                final_byte;
  logic                accept;
  clns_pkg::byte_t     ent;

  always_comb begin
    ent        = '0;
    final_byte = 1'b1;
    unique case (op_q)
      clns_pkg::OP_INIT: begin
        ent.data   = clns_pkg::init_cmd(idx_q);
        ent.pwr    = (idx_q == '0);
        ent.tail   = (idx_q == clns_pkg::INIT_LAST_IDX);
        final_byte = (idx_q == clns_pkg::INIT_LAST_IDX);
      end
      clns_pkg::OP_CMD: begin
        ent.data = val_q;
      end
      clns_pkg::OP_CHAR: begin
        ent.data = val_q;
        ent.rs   = 1'b1;
      end
      clns_pkg::OP_CHAR_AT: begin
        if (has_addr_q && idx_q == '0) begin
          ent.data   = addr_q;
          final_byte = 1'b0;
        end else begin
          ent.data = val_q;
          ent.rs   = 1'b1;
        end
      end
      default: ent = '0;
    endcase
    ent.last = final_byte;
  end

  assign push_valid_o = busy_q;
  assign push_data_o  = ent;
  assign push         = busy_q && push_ready_i;
  assign in_ready_o   = !busy_q || (push && final_byte);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (push) begin
      idx_d = idx_q + 2'd1;
      if (final_byte) busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= clns_pkg::op_e'(in_op_i);
      val_q      <= in_value_i;
      has_addr_q <= (in_line_i == clns_pkg::LINE_FIRST) ||
                    (in_line_i == clns_pkg::LINE_SECOND);
      addr_q     <= ((in_line_i == clns_pkg::LINE_SECOND) ? clns_pkg::ADDR_LINE2
                                                          : clns_pkg::ADDR_LINE1)
                    + {2'b00, in_column_i};
    end
  end

endmodule

[design/clns_fifo.sv]
// ----------------------------------------------------------------------------
// clns_fifo
// Small register queue of byte entries between the front and back parts.
// ----------------------------------------------------------------------------
module clns_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  clns_pkg::byte_t  wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output clns_pkg::byte_t  rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  clns_pkg::byte_t  mem_q [Depth];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
    if (rd) rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
    if (wr && !rd) cnt_d = cnt_q + CW'(1);
    else if (rd && !wr) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

[design/clns_back.sv]
// ----------------------------------------------------------------------------
// clns_back
// Splits each queued byte into a high and a low nibble strobe and registers
// them toward the output.
// ----------------------------------------------------------------------------
module clns_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clns_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  clns_pkg::byte_t  pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_rs_o,
  output logic [3:0]       out_nibble_o,
  output logic [15:0]      out_pre_o,
  output logic [15:0]      out_post_o,
  output logic             out_last_o
);

  logic        valid_q, valid_d;
  logic        low_q, low_d;
  logic        load;
  logic [16:0] tail_sum;
  logic [15:0] low_post;
  logic        rs_q;
  logic [3:0]  nib_q;
  logic [15:0] pre_q, post_q;
  logic        last_q;

  assign load        = pop_valid_i && (!valid_q || out_ready_i);
  assign pop_ready_o = load && low_q;

  assign tail_sum = {9'd0, cfg_i.strobe} + {1'b0, cfg_i.init_tail};
  assign low_post = !pop_data_i.tail ? {8'd0, cfg_i.strobe} :
                    tail_sum[16]     ? 16'hFFFF : tail_sum[15:0];

  always_comb begin
    valid_d = valid_q;
    low_d   = low_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      low_d   = !low_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      low_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= pop_data_i.rs;
      nib_q  <= low_q ? pop_data_i.data[3:0] : pop_data_i.data[7:4];
      pre_q  <= (!low_q && pop_data_i.pwr) ? cfg_i.power_up : '0;
      post_q <= low_q ? low_post : '0;
      last_q <= low_q && pop_data_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_rs_o     = rs_q;
  assign out_nibble_o = nib_q;
  assign out_pre_o    = pre_q;
  assign out_post_o   = post_q;
  assign out_last_o   = last_q;

endmodule

[design/char_lcd_nibble_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character-LCD 4-bit bus sequencer: requests in, nibble strobes out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item (operation in tuser, value, column
//   and line in tdata). m_axis carries one bus strobe per item: rs in tuser,
//   nibble and the pre/post waits in tdata, tlast on the final strobe of a
//   request. The cfg channel writes the three wait registers and is always
//   ready; write it only while no request is in flight.
//   Init gives 8 strobes, command and char give 2, char at position on line
//   1 or 2 gives 4. A request's first strobe passes the front's registers,
//   the queue and the back's output register; then one strobe leaves per
//   cycle while m_axis is ready, set by the nibble splitter in the back part,
//   which emits one strobe per cycle. The front pushes one byte per cycle
//   into the queue while it has room and takes the next request in the cycle
//   it pushes the last byte of the current one, so requests flow back to back.
//   Reset empties the queue, drops any pending strobe and restores the
//   registers to 20000, 40 and 5000 us. When m_axis stalls the output
//   register holds, the queue fills, and then s_axis_tready falls.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value[7:0], column[13:8], line[15:14]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // nibble[3:0], pre_wait_us[19:4],
                                      // post_wait_us[35:20], zero[39:36]
  output logic        m_axis_tuser,   // rs
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  clns_pkg::cfg_t   cfg_q;
  clns_pkg::byte_t  push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [3:0]       nibble;
  logic [15:0]      pre_wait, post_wait;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_up  <= clns_pkg::RST_POWER_UP;
      cfg_q.strobe    <= clns_pkg::RST_STROBE;
      cfg_q.init_tail <= clns_pkg::RST_INIT_TAIL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        clns_pkg::REG_POWER_UP:  cfg_q.power_up  <= cfg_data_i;
        clns_pkg::REG_STROBE:    cfg_q.strobe    <= cfg_data_i[7:0];
        clns_pkg::REG_INIT_TAIL: cfg_q.init_tail <= cfg_data_i;
        default: ;
      endcase
    end
  end

  clns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_value_i   (s_axis_tdata[7:0]),
    .in_column_i  (s_axis_tdata[13:8]),
    .in_line_i    (s_axis_tdata[15:14]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  clns_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  clns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (m_axis_tuser),
    .out_nibble_o (nibble),
    .out_pre_o    (pre_wait),
    .out_post_o   (post_wait),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, post_wait, pre_wait, nibble};

endmodule

[design/clns_checker.sv]
// ----------------------------------------------------------------------------
// clns_checker
// Port-level checks on the strobe stream of the sequencer core.
// ----------------------------------------------------------------------------
module clns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("strobe changed while stalled");

  a_idle_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("strobe valid right after reset");

  a_pre_wait_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[19:4] != 16'd0) |-> !m_axis_tuser && !m_axis_tlast)
    else $error("power-up wait on a data or final strobe");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
    else $error("tdata padding not zero");

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (.*);

[tb/char_lcd_nibble_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_tb
// Drives LCD requests into the sequencer and checks every nibble strobe that
// comes out against an in-bench model of the 4-bit bus protocol. The run
// steps through several wait-register settings, starting from the reset
// values and including all-zero, all-ones and near-saturation settings. Both
// stream sides stall at random, with one phase that runs without stalls.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    clns_pkg::op_e op;
    logic [7:0]    value;
    logic [5:0]    column;
    logic [1:0]    line;
  } req_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] pre;
    logic [15:0] post;
    logic        last;
  } strobe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  req_t        pending_reqs[$];
  strobe_t     expected_strobes[$];
  logic        req_taken = 1'b0;
  logic        no_stalls = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned strobe_cnt = 0;
  int unsigned reg_write_cnt = 0;

  logic [15:0] power_up_us = clns_pkg::RST_POWER_UP;
  logic [7:0]  strobe_us = clns_pkg::RST_STROBE;
  logic [15:0] init_tail_us = clns_pkg::RST_INIT_TAIL;

  char_lcd_nibble_sequencer_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),   // value[7:0], column[13:8], line[15:14]
    .s_axis_tuser(s_axis_tuser),   // operation[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),   // nibble[3:0], pre_wait_us[19:4],
                                   // post_wait_us[35:20], zero[39:36]
    .m_axis_tuser(m_axis_tuser),   // rs
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_byte_strobes(logic rs, logic [7:0] b, logic [15:0] pre,
                                            logic [15:0] post_lo, logic is_last);
    strobe_t s;
    s = '{rs: rs, nibble: b[7:4], pre: pre, post: 16'd0, last: 1'b0};
    expected_strobes.push_back(s);
    s = '{rs: rs, nibble: b[3:0], pre: 16'd0, post: post_lo, last: is_last};
    expected_strobes.push_back(s);
  endfunction

  function automatic void predict_strobes(req_t r);
    int unsigned tail_sum;
    logic [15:0] tail_post;
    tail_sum = int'(strobe_us) + int'(init_tail_us);
    tail_post = (tail_sum > 65535) ? 16'hFFFF : tail_sum[15:0];
    case (r.op)
      clns_pkg::OP_INIT: begin
        push_byte_strobes(1'b0, clns_pkg::CMD_FUNC_SET, power_up_us, {8'd0, strobe_us}, 1'b0);
        push_byte_strobes(1'b0, clns_pkg::CMD_DISP_ON, 16'd0, {8'd0, strobe_us}, 1'b0);
        push_byte_strobes(1'b0, clns_pkg::CMD_ENTRY_MODE, 16'd0, {8'd0, strobe_us}, 1'b0);
        push_byte_strobes(1'b0, clns_pkg::CMD_CLEAR, 16'd0, tail_post, 1'b1);
      end
      clns_pkg::OP_CMD: begin
        push_byte_strobes(1'b0, r.value, 16'd0, {8'd0, strobe_us}, 1'b1);
      end
      default: begin
        if (r.op == clns_pkg::OP_CHAR_AT && r.line == clns_pkg::LINE_FIRST) begin
          push_byte_strobes(1'b0, clns_pkg::ADDR_LINE1 + {2'b00, r.column}, 16'd0,
                            {8'd0, strobe_us}, 1'b0);
        end else if (r.op == clns_pkg::OP_CHAR_AT && r.line == clns_pkg::LINE_SECOND) begin
          push_byte_strobes(1'b0, clns_pkg::ADDR_LINE2 + {2'b00, r.column}, 16'd0,
                            {8'd0, strobe_us}, 1'b0);
        end
        push_byte_strobes(1'b1, r.value, 16'd0, {8'd0, strobe_us}, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch on strobe %0d: %s got 0x%0h, expected 0x%0h",
             strobe_cnt, field, got, want);
    err_cnt++;
  endtask

  // Sample both handshakes and the register writes at the rising edge
  always @(posedge clk_i) begin
    strobe_t want;
    req_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      reg_write_cnt++;
      case (cfg_index_i)
        clns_pkg::REG_POWER_UP:  power_up_us <= cfg_data_i;
        clns_pkg::REG_STROBE:    strobe_us <= cfg_data_i[7:0];
        clns_pkg::REG_INIT_TAIL: init_tail_us <= cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      req_cnt++;
      predict_strobes('{op: clns_pkg::op_e'(s_axis_tuser), value: s_axis_tdata[7:0],
                        column: s_axis_tdata[13:8], line: s_axis_tdata[15:14]});
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_strobes.size() == 0) begin
        $display("unexpected strobe %0d: tdata 0x%0h rs %0b last %0b",
                 strobe_cnt, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_cnt++;
      end else begin
        want = expected_strobes.pop_front();
        if (m_axis_tuser !== want.rs) report_mismatch("rs", {15'd0, m_axis_tuser}, {15'd0, want.rs});
        if (m_axis_tdata[3:0] !== want.nibble)
          report_mismatch("nibble", {12'd0, m_axis_tdata[3:0]}, {12'd0, want.nibble});
        if (m_axis_tdata[19:4] !== want.pre) report_mismatch("pre_wait", m_axis_tdata[19:4], want.pre);
        if (m_axis_tdata[35:20] !== want.post)
          report_mismatch("post_wait", m_axis_tdata[35:20], want.post);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", {15'd0, m_axis_tlast}, {15'd0, want.last});
      end
      strobe_cnt++;
    end
  end

  // Feed requests and toggle the output stall at the falling edge
  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (pending_reqs.size() > 0 && (no_stalls || $urandom_range(99) >= 21)) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.op;
          s_axis_tdata <= {nxt.line, nxt.column, nxt.value};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= no_stalls || ($urandom_range(99) >= 21);
    end
  end

  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) r.op = clns_pkg::OP_INIT;
    else if (pick < 35) r.op = clns_pkg::OP_CMD;
    else if (pick < 60) r.op = clns_pkg::OP_CHAR;
    else r.op = clns_pkg::OP_CHAR_AT;
    r.value = 8'($urandom_range(255));
    r.column = 6'($urandom_range(63));
    r.line = 2'($urandom_range(3));
    return r;
  endfunction

  function automatic void queue_random(int unsigned n);
    repeat (n) pending_reqs.push_back(rand_req());
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_strobes.size() > 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h00, 6'd0, 2'd0});
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'hFF, 6'd63, 2'd3});
    pending_reqs.push_back('{clns_pkg::OP_CMD, 8'h00, 6'd0, 2'd0});
    pending_reqs.push_back('{clns_pkg::OP_CMD, 8'hFF, 6'd63, 2'd1});
    pending_reqs.push_back('{clns_pkg::OP_CMD, 8'hA5, 6'd21, 2'd2});
    pending_reqs.push_back('{clns_pkg::OP_CHAR, 8'h00, 6'd0, 2'd0});
    pending_reqs.push_back('{clns_pkg::OP_CHAR, 8'hFF, 6'd63, 2'd1});
    pending_reqs.push_back('{clns_pkg::OP_CHAR, 8'h5A, 6'd42, 2'd2});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h41, 6'd0, 2'd1});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'hFF, 6'd63, 2'd1});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h00, 6'd0, 2'd2});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h7E, 6'd63, 2'd2});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h30, 6'd17, 2'd0});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'hC3, 6'd63, 2'd3});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h00, 6'd0, 2'd3});
    pending_reqs.push_back('{clns_pkg::OP_CMD, 8'h01, 6'd0, 2'd0});
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h55, 6'd33, 2'd1});
    pending_reqs.push_back('{clns_pkg::OP_CHAR_AT, 8'h2A, 6'd40, 2'd1});
    drain();

    // all ones: tail sum saturates, strobe register masks the upper byte
    write_reg(clns_pkg::REG_POWER_UP, 16'hFFFF);
    write_reg(clns_pkg::REG_STROBE, 16'hFFFF);
    write_reg(clns_pkg::REG_INIT_TAIL, 16'hFFFF);
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h00, 6'd0, 2'd0});
    queue_random(60);
    drain();

    // all zeros, plus a write to the unused index, no stalls
    write_reg(clns_pkg::REG_POWER_UP, 16'h0000);
    write_reg(clns_pkg::REG_STROBE, 16'h0000);
    write_reg(clns_pkg::REG_INIT_TAIL, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    no_stalls = 1'b1;
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h00, 6'd0, 2'd0});
    queue_random(70);
    drain();
    no_stalls = 1'b0;

    // tail sum right at the saturation point
    write_reg(clns_pkg::REG_POWER_UP, 16'h8001);
    write_reg(clns_pkg::REG_STROBE, 16'h00FF);
    write_reg(clns_pkg::REG_INIT_TAIL, 16'hFF00);
    write_reg(REG_UNUSED, 16'h0000);
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h00, 6'd0, 2'd0});
    drain();
    write_reg(clns_pkg::REG_INIT_TAIL, 16'hFF01);
    pending_reqs.push_back('{clns_pkg::OP_INIT, 8'h00, 6'd0, 2'd0});
    drain();

    // random settings, first around the saturation threshold, then anywhere
    write_reg(clns_pkg::REG_POWER_UP, 16'($urandom_range(65535)));
    write_reg(clns_pkg::REG_STROBE, 16'($urandom_range(65535)));
    write_reg(clns_pkg::REG_INIT_TAIL, 16'($urandom_range(65535, 65000)));
    queue_random(45);
    drain();
    write_reg(clns_pkg::REG_POWER_UP, 16'($urandom_range(65535)));
    write_reg(clns_pkg::REG_STROBE, 16'($urandom_range(65535)));
    write_reg(clns_pkg::REG_INIT_TAIL, 16'($urandom_range(65535)));
    queue_random(45);
    drain();

    $display("covered %0d requests and %0d strobes under %0d register writes",
             req_cnt, strobe_cnt, reg_write_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches found", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d strobes still expected", expected_strobes.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
design/clns_pkg.sv
design/clns_front.sv
design/clns_fifo.sv
design/clns_back.sv
design/char_lcd_nibble_sequencer_core.sv
design/clns_checker.sv
tb/char_lcd_nibble_sequencer_core_tb.sv
